[rtl/core/sobv_pkg.sv]
package sobv_pkg;

    // fixed field and register widths
    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // input kinds carried on tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // output queue geometry
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = 3;
    localparam int OUTQ_CW    = 4;

    // one result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             eof;
    } t_result;

    // control of one item in the window stage
    typedef struct packed {
        logic valid;
        logic first;
        logic drain;
        logic emit_mid;
        logic emit_end;
    } t_stage_ctl;

    // bottom row minus top row of the kernel, clamped to 0..255
    function automatic logic [PIX_W-1:0] sobel_clamp(
        input logic [PIX_W-1:0] t0,
        input logic [PIX_W-1:0] t1,
        input logic [PIX_W-1:0] t2,
        input logic [PIX_W-1:0] b0,
        input logic [PIX_W-1:0] b1,
        input logic [PIX_W-1:0] b2
    );
        logic [PIX_W+1:0] top;
        logic [PIX_W+1:0] bot;
        logic [PIX_W+2:0] diff;
        logic [PIX_W-1:0] res;
        top  = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
        bot  = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, b2};
        diff = {1'b0, bot} - {1'b0, top};
        if (diff[PIX_W+2]) begin
            res = '0;
        end else if (diff[PIX_W+1:PIX_W] != 2'b00) begin
            res = '1;
        end else begin
            res = diff[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/sobv_line_mem.sv]
module sobv_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-old-data on a same-address collision, the caller forwards
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sobv_kernel.sv]
module sobv_kernel (
    input  logic                      i_clk,
    input  sobv_pkg::t_stage_ctl      i_ctl,
    input  logic [sobv_pkg::PIX_W-1:0] i_above,
    input  logic [sobv_pkg::PIX_W-1:0] i_px,
    output logic                      o_push0,
    output sobv_pkg::t_result         o_data0,
    output logic                      o_push1,
    output sobv_pkg::t_result         o_data1
);

    // only the top and bottom rows of the window reach the kernel
    logic [sobv_pkg::PIX_W-1:0] r_top [3];
    logic [sobv_pkg::PIX_W-1:0] r_bot [3];
    logic [sobv_pkg::PIX_W-1:0] n_top [3];
    logic [sobv_pkg::PIX_W-1:0] n_bot [3];
    logic [sobv_pkg::PIX_W-1:0] res_mid;
    logic [sobv_pkg::PIX_W-1:0] res_end;

    always_comb begin
        n_top = r_top;
        n_bot = r_bot;
        if (i_ctl.valid) begin
            if (i_ctl.first) begin
                n_top[0] = '0;
                n_top[1] = '0;
                n_bot[0] = '0;
                n_bot[1] = '0;
            end else begin
                n_top[0] = r_top[1];
                n_top[1] = r_top[2];
                n_bot[0] = r_bot[1];
                n_bot[1] = r_bot[2];
            end
            n_top[2] = i_above;
            n_bot[2] = i_px;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_bot <= n_bot;
    end

    always_comb begin
        res_mid = sobv_pkg::sobel_clamp(n_top[0], n_top[1], n_top[2],
                                        n_bot[0], n_bot[1], n_bot[2]);
        // right border: zero column on the right
        res_end = sobv_pkg::sobel_clamp(n_top[1], n_top[2], '0,
                                        n_bot[1], n_bot[2], '0);
    end

    assign o_push0       = i_ctl.valid & i_ctl.emit_mid;
    assign o_data0.pixel = res_mid;
    assign o_data0.last  = ~i_ctl.emit_end;
    assign o_data0.eof   = 1'b0;
    assign o_push1       = i_ctl.valid & i_ctl.emit_end;
    assign o_data1.pixel = res_end;
    assign o_data1.last  = 1'b1;
    assign o_data1.eof   = i_ctl.drain;

endmodule

[rtl/core/sobv_outq.sv]
module sobv_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push0,
    input  sobv_pkg::t_result             i_data0,
    input  logic                          i_push1,
    input  sobv_pkg::t_result             i_data1,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sobv_pkg::t_result             o_data,
    output logic [sobv_pkg::OUTQ_CW-1:0]  o_level
);

    sobv_pkg::t_result              r_mem [sobv_pkg::OUTQ_DEPTH];
    logic [sobv_pkg::OUTQ_AW-1:0]   r_wr_ptr;
    logic [sobv_pkg::OUTQ_AW-1:0]   r_rd_ptr;
    logic [sobv_pkg::OUTQ_CW-1:0]   r_count;
    logic [sobv_pkg::OUTQ_AW-1:0]   slot1;
    logic [sobv_pkg::OUTQ_CW-1:0]   push_n;
    logic                           pop;

    assign pop    = o_valid & i_ready;
    assign slot1  = r_wr_ptr + sobv_pkg::OUTQ_AW'(i_push0);
    assign push_n = sobv_pkg::OUTQ_CW'(i_push0) + sobv_pkg::OUTQ_CW'(i_push1);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[slot1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[sobv_pkg::OUTQ_AW-1:0];
            r_rd_ptr <= r_rd_ptr + sobv_pkg::OUTQ_AW'(pop);
            r_count  <= r_count + push_n - sobv_pkg::OUTQ_CW'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_count;

endmodule

[rtl/core/sobel_vertical_edge_filter.sv]
// 3x3 sobel filter (bottom row minus top row), zero padded, clamped to 0..255
//
// input stream: one transaction per raster pixel (tuser = 0, tdata = grey level);
// after the last pixel of a frame, one drain transaction per column (tuser = 1)
// flushes the last row. pixels of row r give the outputs of row r-1, the last
// pixel of a row gives two, row 0 gives none; a drain before the frame is in,
// or a pixel after it, is taken and dropped.
// output stream: one transaction per image pixel in raster order; tlast marks
// the final output caused by an input transaction, tuser marks the frame's last.
// path: an input transaction is registered in the window stage, and its results
// are pushed into the output queue, which hands them out one at a time.
// throughput: one input transaction per cycle while the output side keeps up;
// the line memory takes one read and one write each cycle, set by its single
// write port. an 8-entry output queue parts the two sides, so a stalled receiver
// holds back input once the queue lacks room for two results each from the
// staged transaction and a new one.
// reset: a clearing pass writes zeros to all MAX_WIDTH line memory entries,
// one per cycle, with s_axis_tready low; configuration writes are taken always.
// image_width and image_height are written through i_cfg_* while no frame is
// in flight; width 0 acts as 1, above MAX_WIDTH as MAX_WIDTH, height 0 as 1.
module sobel_vertical_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [sobv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sobv_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel_in
    input  logic [0:0]                        s_axis_tuser,   // [0] cmd
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] pixel_out
    output logic                              m_axis_tlast,   // last_of_item
    output logic [0:0]                        m_axis_tuser    // [0] end_of_frame
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > sobv_pkg::WIDTH_REG_W) ? WW : sobv_pkg::WIDTH_REG_W;
    localparam int HW   = sobv_pkg::HEIGHT_REG_W;
    localparam int PW   = sobv_pkg::PIX_W;
    localparam int QCW  = sobv_pkg::OUTQ_CW;

    // configuration registers
    logic [sobv_pkg::WIDTH_REG_W-1:0] r_width;
    logic [HW-1:0]                    r_height;

    // position counters
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [HW-1:0] r_row;
    logic [HW-1:0] n_row;

    // clearing pass after reset
    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;

    // window stage registers
    sobv_pkg::t_stage_ctl r_b;
    sobv_pkg::t_stage_ctl n_b;
    logic [PW-1:0]        r_b_px;
    logic [CW-1:0]        r_b_addr;
    logic                 r_b_row0;

    // forwarding of a write that collides with the next read
    logic          r_fwd;
    logic [PW-1:0] r_fwd_above;
    logic [PW-1:0] r_fwd_mid;

    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic              in_fire;
    logic              is_drain;
    logic              frame_in;
    logic              take;
    logic [WW-1:0]     col_inc;
    logic              row_end;
    logic [HW:0]       row_inc;
    logic              emits;
    logic [2*PW-1:0]   rd_data;
    logic [PW-1:0]     above_eff;
    logic [PW-1:0]     mid_eff;
    logic [PW-1:0]     wr_above;
    logic              b_write;
    logic              mem_we;
    logic [CW-1:0]     mem_waddr;
    logic [2*PW-1:0]   mem_wdata;
    logic [QCW:0]      q_need;

    logic              k_push0;
    logic              k_push1;
    sobv_pkg::t_result k_data0;
    sobv_pkg::t_result k_data1;
    sobv_pkg::t_result q_data;
    logic [QCW-1:0]    q_level;

    // effective geometry
    always_comb begin
        if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else if (r_width == '0) begin
            w_eff = WW'(1);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == '0) ? HW'(1) : r_height;
    end

    // accept decision and counter update
    always_comb begin
        in_fire  = s_axis_tvalid & s_axis_tready;
        is_drain = (s_axis_tuser[0] == sobv_pkg::CMD_DRAIN);
        frame_in = (r_row >= h_eff);
        take     = in_fire & (is_drain ? frame_in : ~frame_in);
        col_inc  = WW'(r_col) + WW'(1);
        row_end  = (col_inc >= w_eff);
        row_inc  = {1'b0, r_row} + (HW+1)'(1);
        emits    = is_drain | (r_row != '0);

        n_col = r_col;
        n_row = r_row;
        if (take) begin
            if (row_end) begin
                n_col = '0;
                if (is_drain) begin
                    n_row = '0;
                end else if (row_inc >= {1'b0, h_eff}) begin
                    n_row = h_eff;
                end else begin
                    n_row = row_inc[HW-1:0];
                end
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end

        n_b.valid    = take;
        n_b.first    = (r_col == '0);
        n_b.drain    = is_drain;
        n_b.emit_mid = emits & (r_col != '0);
        n_b.emit_end = emits & row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sobv_pkg::WIDTH_REG_W'(1024);
            r_height <= HW'(768);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sobv_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_wdata[sobv_pkg::WIDTH_REG_W-1:0];
                end
                sobv_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_wdata[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b        <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_b   <= n_b;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // payload of the window stage
    always_ff @(posedge i_clk) begin
        r_b_px      <= is_drain ? '0 : s_axis_tdata[PW-1:0];
        r_b_addr    <= r_col;
        r_b_row0    <= (r_row == '0);
        r_fwd       <= b_write & (r_b_addr == r_col);
        r_fwd_above <= wr_above;
        r_fwd_mid   <= r_b_px;
    end

    // read-modify-write of the line memory: {upper row, middle row}
    always_comb begin
        above_eff = r_fwd ? r_fwd_above : rd_data[2*PW-1:PW];
        mid_eff   = r_fwd ? r_fwd_mid   : rd_data[PW-1:0];
        // on row 0 the upper row is zeroed so no old frame reaches the top padding
        wr_above  = r_b_row0 ? '0 : mid_eff;
        b_write   = r_b.valid & ~r_b.drain;
        mem_we    = r_clr_busy | b_write;
        mem_waddr = r_clr_busy ? r_clr_addr : r_b_addr;
        mem_wdata = r_clr_busy ? '0 : {wr_above, r_b_px};
    end

    sobv_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2 * PW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    sobv_kernel u_kernel (
        .i_clk   (i_clk),
        .i_ctl   (r_b),
        .i_above (above_eff),
        .i_px    (r_b_px),
        .o_push0 (k_push0),
        .o_data0 (k_data0),
        .o_push1 (k_push1),
        .o_data1 (k_data1)
    );

    sobv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (k_push0),
        .i_data0 (k_data0),
        .i_push1 (k_push1),
        .i_data1 (k_data1),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_data),
        .o_level (q_level)
    );

    // room for the item in the window stage and for this one, two results each
    always_comb begin
        q_need        = {1'b0, q_level} + (r_b.valid ? (QCW+1)'(2) : '0);
        s_axis_tready = ~r_clr_busy & (q_need <= (QCW+1)'(sobv_pkg::OUTQ_DEPTH - 2));
    end

    assign m_axis_tdata    = q_data.pixel;
    assign m_axis_tlast    = q_data.last;
    assign m_axis_tuser[0] = q_data.eof;

`ifndef SYNTHESIS
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("end of frame on a result that is not the last of its item");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_WIDTH - 1))
        else $error("column counter beyond line memory");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready && !r_b.valid)
        else $error("item in flight during line memory clearing");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= QCW'(sobv_pkg::OUTQ_DEPTH))
        else $error("output queue overflow");
`endif

endmodule
